### hdl/double_ended_queue_top_defines.svh
// Assertion macros used by the double-ended queue top level.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define DEQ_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the cycle after an antecedent.
`define DEQ_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/deq_pkg.sv
// Types, constants and helpers for the double-ended queue.
package deq_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_BITS  = 31;
  localparam int OUT_BITS    = 32;
  localparam int MODE_BITS   = 3;
  localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
  localparam int S_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
  localparam int RESULT_BITS = 3 * OUT_BITS + COUNT_BITS + 2;
  localparam int M_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

  localparam logic signed [OUT_BITS-1:0] NEG_ONE = '1;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_QUERY      = 3'd4
  } deq_mode_t;

  typedef logic [VALUE_BITS-1:0] deq_value_t;

  typedef struct packed {
    logic ins_front;
    logic ins_back;
    logic del_front;
    logic del_back;
  } deq_cmd_t;

  typedef struct packed {
    logic                  full;
    logic                  empty;
    logic [COUNT_BITS-1:0] count;
  } deq_status_t;

  typedef struct packed {
    logic                       push_dropped;
    logic signed [OUT_BITS-1:0] back_value;
    logic signed [OUT_BITS-1:0] front_value;
    logic                       is_empty;
    logic [COUNT_BITS-1:0]      entry_total;
    logic signed [OUT_BITS-1:0] popped_value;
  } deq_result_t;

  function automatic logic [OUT_BITS-1:0] to_out(input deq_value_t v);
    logic [OUT_BITS+VALUE_BITS-1:0] wide;
    wide = {{OUT_BITS{1'b0}}, v};
    return wide[OUT_BITS-1:0];
  endfunction

endpackage

### hdl/deq_cell.sv
// One cell of the queue row: a front-ordered slot, a back-ordered slot and a position flag.
module deq_cell (
  input  logic                clk,
  input  logic                rst,
  input  deq_pkg::deq_cmd_t   cmd,
  input  deq_pkg::deq_value_t value,
  input  deq_pkg::deq_value_t a_left,
  input  deq_pkg::deq_value_t a_right,
  input  deq_pkg::deq_value_t b_left,
  input  deq_pkg::deq_value_t b_right,
  input  logic                over_left,
  input  logic                over_right,
  output deq_pkg::deq_value_t a,
  output deq_pkg::deq_value_t b,
  output logic                over
);
  import deq_pkg::*;

  logic write_pt;

  // first free slot: this cell is past the end, its left neighbour is not
  assign write_pt = over && !over_left;

  always_ff @(posedge clk) begin
    if (cmd.ins_front) begin
      a <= a_left;
    end else if (cmd.del_front) begin
      a <= a_right;
    end else if (cmd.ins_back && write_pt) begin
      a <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_back) begin
      b <= b_left;
    end else if (cmd.del_back) begin
      b <= b_right;
    end else if (cmd.ins_front && write_pt) begin
      b <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      over <= 1'b1;
    end else if (cmd.ins_front || cmd.ins_back) begin
      over <= over_left;
    end else if (cmd.del_front || cmd.del_back) begin
      over <= over_right;
    end
  end

endmodule

### hdl/deq_ctrl.sv
// Request handshake, entry count and result register of the queue.
module deq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  deq_pkg::deq_mode_t   mode,
  input  deq_pkg::deq_value_t  value,
  input  deq_pkg::deq_value_t  a0,
  input  deq_pkg::deq_value_t  a1,
  input  deq_pkg::deq_value_t  b0,
  input  deq_pkg::deq_value_t  b1,
  input  logic                 res_ready,
  output logic                 res_valid,
  output deq_pkg::deq_result_t res,
  output deq_pkg::deq_cmd_t    cmd,
  output deq_pkg::deq_status_t status
);
  import deq_pkg::*;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  fire;
  logic                  full;
  logic                  empty;
  logic                  do_pf;
  logic                  do_pb;
  logic                  do_qf;
  logic                  do_qb;
  logic                  dropped;
  deq_result_t           res_next;

  assign req_ready = !res_valid || res_ready;
  assign fire      = req_valid && req_ready;
  assign full      = (count == COUNT_BITS'(CAPACITY));
  assign empty     = (count == '0);

  assign status.full  = full;
  assign status.empty = empty;
  assign status.count = count;

  always_comb begin
    do_pf   = 1'b0;
    do_pb   = 1'b0;
    do_qf   = 1'b0;
    do_qb   = 1'b0;
    dropped = 1'b0;
    unique case (mode)
      MODE_PUSH_FRONT: begin
        dropped = full;
        do_pf   = !full;
      end
      MODE_PUSH_BACK: begin
        dropped = full;
        do_pb   = !full;
      end
      MODE_POP_FRONT: do_qf = !empty;
      MODE_POP_BACK:  do_qb = !empty;
      default: ;
    endcase
  end

  assign cmd.ins_front = fire && do_pf;
  assign cmd.ins_back  = fire && do_pb;
  assign cmd.del_front = fire && do_qf;
  assign cmd.del_back  = fire && do_qb;

  always_comb begin
    priority if (do_pf || do_pb) begin
      count_next = count + COUNT_BITS'(1);
    end else if (do_qf || do_qb) begin
      count_next = count - COUNT_BITS'(1);
    end else begin
      count_next = count;
    end
  end

  always_comb begin
    res_next.push_dropped = dropped;
    res_next.entry_total  = count_next;
    res_next.is_empty     = (count_next == '0);

    priority if (do_qf) begin
      res_next.popped_value = to_out(a0);
    end else if (do_qb) begin
      res_next.popped_value = to_out(b0);
    end else begin
      res_next.popped_value = NEG_ONE;
    end

    priority if (count_next == '0) begin
      res_next.front_value = NEG_ONE;
    end else if (do_pf || (do_pb && empty)) begin
      res_next.front_value = to_out(value);
    end else if (do_qf) begin
      res_next.front_value = to_out(a1);
    end else begin
      res_next.front_value = to_out(a0);
    end

    priority if (count_next == '0) begin
      res_next.back_value = NEG_ONE;
    end else if (do_pb || (do_pf && empty)) begin
      res_next.back_value = to_out(value);
    end else if (do_qb) begin
      res_next.back_value = to_out(b1);
    end else begin
      res_next.back_value = to_out(b0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else if (fire) begin
      count     <= count_next;
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

### hdl/double_ended_queue_top.sv
// Bounded double-ended queue built as a row of shifting cells.
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle while the result side keeps taking results;
// every cell of the row shifts or loads in the same cycle, so no operation waits.
// Reset clears the entry count and the cell position flags at once; no clearing
// pass, and slot contents stay undefined until pushed.
module double_ended_queue_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // push_value
  input  logic [deq_pkg::S_DATA_BITS-1:0] s_axis_tdata,
  // mode
  input  logic [deq_pkg::MODE_BITS-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // popped_value, entry_total, is_empty, front_value, back_value, push_dropped
  output logic [deq_pkg::M_DATA_BITS-1:0] m_axis_tdata
);
  import deq_pkg::*;

  `include "double_ended_queue_top_defines.svh"

  deq_value_t    push_value;
  deq_mode_t     mode;
  deq_cmd_t      cmd;
  deq_status_t   status;
  deq_result_t   res;
  logic          s_fire;
  deq_value_t    a_vec [CAPACITY];
  deq_value_t    b_vec [CAPACITY];
  logic [CAPACITY-1:0] over_vec;

  assign push_value = s_axis_tdata[VALUE_BITS-1:0];
  assign mode       = deq_mode_t'(s_axis_tuser);
  assign s_fire     = s_axis_tvalid && s_axis_tready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    deq_value_t a_l;
    deq_value_t a_r;
    deq_value_t b_l;
    deq_value_t b_r;
    logic       o_l;
    logic       o_r;

    if (i == 0) begin : g_head
      assign a_l = push_value;
      assign b_l = push_value;
      assign o_l = 1'b0;
    end else begin : g_body
      assign a_l = a_vec[i-1];
      assign b_l = b_vec[i-1];
      assign o_l = over_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign a_r = a_vec[i];
      assign b_r = b_vec[i];
      assign o_r = 1'b1;
    end else begin : g_inner
      assign a_r = a_vec[i+1];
      assign b_r = b_vec[i+1];
      assign o_r = over_vec[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .value      (push_value),
      .a_left     (a_l),
      .a_right    (a_r),
      .b_left     (b_l),
      .b_right    (b_r),
      .over_left  (o_l),
      .over_right (o_r),
      .a          (a_vec[i]),
      .b          (b_vec[i]),
      .over       (over_vec[i])
    );
  end

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .mode      (mode),
    .value     (push_value),
    .a0        (a_vec[0]),
    .a1        (a_vec[1]),
    .b0        (b_vec[0]),
    .b1        (b_vec[1]),
    .res_ready (m_axis_tready),
    .res_valid (m_axis_tvalid),
    .res       (res),
    .cmd       (cmd),
    .status    (status)
  );

  assign m_axis_tdata = M_DATA_BITS'(res);

  `DEQ_CHECK(a_over_thermo, ((~over_vec) & ((~over_vec) + 1'b1)) == '0, "position flags not contiguous")
  `DEQ_CHECK(a_over_count, $countones(~over_vec) == int'(status.count), "position flags disagree with count")
  `DEQ_CHECK(a_head_empty, over_vec[0] == status.empty, "head flag disagrees with empty")
  `DEQ_CHECK_NEXT(a_push_front, s_fire && (mode == MODE_PUSH_FRONT) && !status.full, a_vec[0] == $past(push_value), "front slot missed push")
  `DEQ_CHECK_NEXT(a_push_back, s_fire && (mode == MODE_PUSH_BACK) && !status.full, b_vec[0] == $past(push_value), "back slot missed push")

endmodule

### test/tb_double_ended_queue_top.sv
// Self-checking testbench for the bounded double-ended queue stream block.
module tb_double_ended_queue_top;
  import deq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_OPS     = 600;
  localparam int LONG_HOLD      = 80;
  localparam int MAX_REQUESTS   = 1024;
  localparam int MODE_TOP       = (1 << MODE_BITS) - 1;

  typedef struct {
    logic [MODE_BITS-1:0] mode;
    deq_value_t           value;
  } deq_request_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_DATA_BITS-1:0] s_axis_tdata = '0;
  logic [MODE_BITS-1:0]   s_axis_tuser = MODE_QUERY;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_axis_tdata;

  deq_request_t  pending_requests[MAX_REQUESTS];
  deq_result_t   expected_results[MAX_REQUESTS];
  deq_request_t  sent_request;
  int            request_total = 0;
  int            request_next  = 0;
  int            expect_wr     = 0;
  int            expect_rd     = 0;

  // Shadow copy of the queue contents
  deq_value_t    shadow_slots[CAPACITY];
  int unsigned   shadow_front;
  int unsigned   shadow_back;
  int unsigned   shadow_held;

  int            mismatches;
  int            results_seen;
  int            idle_cycles;
  int            send_gap;
  int            send_quiet;
  int            take_gap;
  int            take_quiet;
  int            hold_left;

  double_ended_queue_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic deq_result_t apply_request(logic [MODE_BITS-1:0] mode,
                                                deq_value_t value);
    deq_result_t r;
    r = '0;
    r.popped_value = NEG_ONE;
    case (mode)
      MODE_PUSH_FRONT: begin
        if (shadow_held >= CAPACITY) begin
          r.push_dropped = 1'b1;
        end else begin
          shadow_front = (shadow_front == 0) ? CAPACITY - 1 : shadow_front - 1;
          shadow_slots[shadow_front] = value;
          shadow_held++;
        end
      end
      MODE_PUSH_BACK: begin
        if (shadow_held >= CAPACITY) begin
          r.push_dropped = 1'b1;
        end else begin
          shadow_slots[shadow_back] = value;
          shadow_back = (shadow_back == CAPACITY - 1) ? 0 : shadow_back + 1;
          shadow_held++;
        end
      end
      MODE_POP_FRONT: begin
        if (shadow_held != 0) begin
          r.popped_value = {1'b0, shadow_slots[shadow_front]};
          shadow_front = (shadow_front == CAPACITY - 1) ? 0 : shadow_front + 1;
          shadow_held--;
        end
      end
      MODE_POP_BACK: begin
        if (shadow_held != 0) begin
          shadow_back = (shadow_back == 0) ? CAPACITY - 1 : shadow_back - 1;
          r.popped_value = {1'b0, shadow_slots[shadow_back]};
          shadow_held--;
        end
      end
      default: ;
    endcase
    r.entry_total = shadow_held[COUNT_BITS-1:0];
    r.is_empty    = (shadow_held == 0);
    if (shadow_held == 0) begin
      r.front_value = NEG_ONE;
      r.back_value  = NEG_ONE;
    end else begin
      r.front_value = {1'b0, shadow_slots[shadow_front]};
      r.back_value  = {1'b0, shadow_slots[(shadow_back == 0) ? CAPACITY - 1 : shadow_back - 1]};
    end
    return r;
  endfunction

  function automatic int compare_field(string field, logic [OUT_BITS-1:0] want,
                                       logic [OUT_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic add_request(logic [MODE_BITS-1:0] mode, deq_value_t value);
    deq_request_t req;
    req.mode  = mode;
    req.value = value;
    pending_requests[request_total] = req;
    request_total++;
  endtask

  function automatic deq_value_t any_value();
    return deq_value_t'($urandom());
  endfunction

  function automatic logic [MODE_BITS-1:0] pick_mode(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return MODE_QUERY;
    if (roll < 9) return MODE_BITS'($urandom_range(int'(MODE_QUERY) + 1, MODE_TOP));
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    int push_pct;
    // Directed opening: empty pops, spare codes, extreme values at both ends
    add_request(MODE_QUERY, '0);
    add_request(MODE_POP_FRONT, '1);
    add_request(MODE_POP_BACK, '1);
    for (int m = int'(MODE_QUERY) + 1; m <= MODE_TOP; m++)
      add_request(MODE_BITS'(m), any_value());
    add_request(MODE_PUSH_BACK, '0);
    add_request(MODE_PUSH_FRONT, '1);
    add_request(MODE_QUERY, '1);
    add_request(MODE_PUSH_BACK, 31'h5555_5555);
    add_request(MODE_PUSH_FRONT, 31'h2AAA_AAAA);
    add_request(MODE_POP_FRONT, '0);
    add_request(MODE_POP_BACK, '0);
    add_request(MODE_POP_FRONT, '0);
    add_request(MODE_POP_BACK, '0);
    add_request(MODE_POP_BACK, '0);
    add_request(MODE_PUSH_FRONT, 31'd1);
    add_request(MODE_POP_BACK, '0);
    add_request(MODE_PUSH_BACK, '1);
    add_request(MODE_POP_FRONT, '0);
    add_request(MODE_POP_FRONT, '0);
    // Random mix in segments of varying push pressure
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 50 == 0) push_pct = $urandom_range(20, 80);
      add_request(pick_mode(push_pct), any_value());
    end
    for (int i = 0; i < 20; i++) add_request(pick_mode(60), any_value());

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (request_next != request_total || s_axis_tvalid || expect_rd != expect_wr);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expect_rd == expect_wr) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Request driver
  always @(posedge clk) begin
    deq_request_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
      send_quiet    <= 0;
      shadow_front  = 0;
      shadow_back   = 0;
      shadow_held   = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results[expect_wr] = apply_request(sent_request.mode, sent_request.value);
        expect_wr++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (request_next < request_total) begin
          req = pending_requests[request_next];
          request_next++;
          sent_request  <= req;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= S_DATA_BITS'(req.value);
          s_axis_tuser  <= req.mode;
          if (send_quiet > 0) begin
            send_quiet <= send_quiet - 1;
            send_gap   <= 0;
          end else if ($urandom_range(0, 19) == 0) begin
            send_quiet <= $urandom_range(20, 60);
            send_gap   <= 0;
          end else begin
            send_gap   <= $urandom_range(0, 3);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    deq_result_t got;
    deq_result_t want;
    int          bad;
    if (rst) begin
      m_axis_tready <= 1'b0;
      take_gap      <= 0;
      take_quiet    <= 0;
      hold_left     <= 0;
      results_seen  <= 0;
      mismatches    <= 0;
    end else begin
      bad = 0;
      if (m_axis_tvalid && m_axis_tready) begin
        got = deq_result_t'(m_axis_tdata[RESULT_BITS-1:0]);
        if (expect_rd == expect_wr) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          bad = 1;
        end else begin
          want = expected_results[expect_rd];
          expect_rd++;
          bad += compare_field("popped_value", want.popped_value, got.popped_value);
          bad += compare_field("entry_total", OUT_BITS'(want.entry_total),
                               OUT_BITS'(got.entry_total));
          bad += compare_field("is_empty", OUT_BITS'(want.is_empty), OUT_BITS'(got.is_empty));
          bad += compare_field("front_value", want.front_value, got.front_value);
          bad += compare_field("back_value", want.back_value, got.back_value);
          bad += compare_field("push_dropped", OUT_BITS'(want.push_dropped),
                               OUT_BITS'(got.push_dropped));
        end
        mismatches   <= mismatches + bad;
        results_seen <= results_seen + 1;
        // Long hold-off so the block backs up and stalls its input
        if (results_seen == 150 || results_seen == 450) begin
          hold_left     <= LONG_HOLD;
          m_axis_tready <= 1'b0;
        end else if (take_quiet > 0) begin
          take_quiet    <= take_quiet - 1;
          m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
          take_quiet    <= $urandom_range(20, 60);
          m_axis_tready <= 1'b1;
        end else begin
          take_gap      <= $urandom_range(0, 3);
          m_axis_tready <= 1'b0;
        end
      end else if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap      <= take_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
